@@ design/rlst_pkg.sv @@
// Shared types and constants for the RPC request latency statistics block.
package rlst_pkg;

  localparam int TABLE_COUNT = 8;
  localparam int SLOT_W = 3;
  localparam int CFG_AW = 5;
  localparam int S_TDATA_W = 120;
  localparam int M_TDATA_W = 136;

  localparam logic [2:0] REG_FILE_PROG = 3'd0;
  localparam logic [2:0] REG_MOUNT_PROG = 3'd1;
  localparam logic [2:0] REG_LOCK_PROG = 3'd2;
  localparam logic [2:0] REG_QUOTA_PROG = 3'd3;
  localparam logic [2:0] REG_LOCK_EN = 3'd4;
  localparam logic [2:0] REG_QUOTA_EN = 3'd5;

  localparam logic [31:0] FILE_PROG_RST = 32'd100003;
  localparam logic [31:0] MOUNT_PROG_RST = 32'd100005;
  localparam logic [31:0] LOCK_PROG_RST = 32'd100021;
  localparam logic [31:0] QUOTA_PROG_RST = 32'd100011;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_PROG = 2'd1;
  localparam logic [1:0] STATUS_BAD_VERS = 2'd2;
  localparam logic [1:0] STATUS_BAD_PROC = 2'd3;

  localparam logic [SLOT_W-1:0] SLOT_FILE2 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_FILE3 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_FILE4 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_MNT1 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_MNT3 = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_LOCK4 = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_QUOTA1 = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_QUOTA2 = 3'd7;

  typedef struct packed {
    logic [31:0] file_prog;
    logic [31:0] mount_prog;
    logic [31:0] lock_prog;
    logic [31:0] quota_prog;
    logic        lock_en;
    logic        quota_en;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } sel_t;

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] success;
    logic [31:0] dropped;
    logic [31:0] min_lat;
    logic [31:0] max_lat;
    logic [63:0] lat_sum;
    logic [63:0] wait_sum;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

endpackage

@@ design/rlst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module rlst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/rlst_cfg.sv @@
// Configuration register file behind the APB-style port.
module rlst_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rlst_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output rlst_pkg::cfg_t            cfg
);
  import rlst_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.file_prog <= FILE_PROG_RST;
      cfg.mount_prog <= MOUNT_PROG_RST;
      cfg.lock_prog <= LOCK_PROG_RST;
      cfg.quota_prog <= QUOTA_PROG_RST;
      cfg.lock_en <= 1'b1;
      cfg.quota_en <= 1'b1;
    end else if (wr) begin
      case (paddr[4:2])
        REG_FILE_PROG: cfg.file_prog <= pwdata;
        REG_MOUNT_PROG: cfg.mount_prog <= pwdata;
        REG_LOCK_PROG: cfg.lock_prog <= pwdata;
        REG_QUOTA_PROG: cfg.quota_prog <= pwdata;
        REG_LOCK_EN: cfg.lock_en <= pwdata[0];
        REG_QUOTA_EN: cfg.quota_en <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_FILE_PROG: prdata = cfg.file_prog;
      REG_MOUNT_PROG: prdata = cfg.mount_prog;
      REG_LOCK_PROG: prdata = cfg.lock_prog;
      REG_QUOTA_PROG: prdata = cfg.quota_prog;
      REG_LOCK_EN: prdata = {31'd0, cfg.lock_en};
      REG_QUOTA_EN: prdata = {31'd0, cfg.quota_en};
      default: prdata = 32'd0;
    endcase
  end

endmodule

@@ design/rlst_decode.sv @@
// Program, version and procedure decode that selects a table or an error status.
module rlst_decode #(
  parameter int PROC_SLOTS = 32
) (
  input  rlst_pkg::cfg_t cfg,
  input  logic [31:0]    program_req,
  input  logic [7:0]     version,
  input  logic [7:0]     procedure,
  output rlst_pkg::sel_t sel
);
  import rlst_pkg::*;

  localparam logic [7:0] VERS_1 = 8'd1;
  localparam logic [7:0] VERS_2 = 8'd2;
  localparam logic [7:0] VERS_3 = 8'd3;
  localparam logic [7:0] VERS_4 = 8'd4;

  always_comb begin
    sel.status = STATUS_OK;
    sel.slot = SLOT_FILE2;
    if (program_req == cfg.file_prog) begin
      case (version)
        VERS_2: sel.slot = SLOT_FILE2;
        VERS_3: sel.slot = SLOT_FILE3;
        VERS_4: sel.slot = SLOT_FILE4;
        default: sel.status = STATUS_BAD_VERS;
      endcase
    end else if (program_req == cfg.mount_prog) begin
      case (version)
        VERS_1: sel.slot = SLOT_MNT1;
        VERS_3: sel.slot = SLOT_MNT3;
        default: sel.status = STATUS_BAD_VERS;
      endcase
    end else if (cfg.lock_en && program_req == cfg.lock_prog) begin
      case (version)
        VERS_4: sel.slot = SLOT_LOCK4;
        default: sel.status = STATUS_BAD_VERS;
      endcase
    end else if (cfg.quota_en && program_req == cfg.quota_prog) begin
      case (version)
        VERS_1: sel.slot = SLOT_QUOTA1;
        VERS_2: sel.slot = SLOT_QUOTA2;
        default: sel.status = STATUS_BAD_VERS;
      endcase
    end else begin
      sel.status = STATUS_BAD_PROG;
    end
    if (sel.status == STATUS_OK && 9'(procedure) >= 9'(PROC_SLOTS)) begin
      sel.status = STATUS_BAD_PROC;
    end
  end

endmodule

@@ design/rpc_request_latency_stats_top.sv @@
// Top level of the RPC request latency statistics block.
// Each accepted request record goes through the idle and update states: the transfer issues
// the read of the entry memory, and the update state, once the output register is free,
// updates the entry from the read data and writes it back, so no new record is taken until
// that update is done. The result goes to an output register, so the next record is taken while a
// result waits. After reset a clearing pass zeroes all 8*PROC_SLOTS entries of the entry memory,
// during which s_tready stays low; configuration writes are taken at any time.
module rpc_request_latency_stats_top #(
  parameter int PROC_SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // program_req[31:0], version[39:32], procedure[47:40], latency[79:48],
  // wait_time[111:80], succeeded[112], zero fill[119:113]
  input  logic [rlst_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[1:0], table_slot[4:2], entry_total[36:5], entry_min_latency[68:37],
  // entry_max_latency[100:69], table_requests[132:101], zero fill[135:133]
  output logic [rlst_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rlst_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rlst_pkg::*;

  localparam int ENTRIES = TABLE_COUNT * PROC_SLOTS;
  localparam int ENTRY_AW = $clog2(ENTRIES);
  localparam logic [ENTRY_AW-1:0] LAST_ENTRY = ENTRY_AW'(ENTRIES - 1);

  cfg_t cfg;
  sel_t in_sel;
  state_t state, state_next;

  logic [31:0] in_program_req;
  logic [7:0]  in_version;
  logic [7:0]  in_procedure;
  logic [31:0] in_latency;
  logic [31:0] in_wait_time;
  logic        in_succeeded;
  logic        accept;
  logic [ENTRY_AW-1:0] rd_addr;

  logic [ENTRY_AW-1:0] clr_addr;
  sel_t                item_sel;
  logic [ENTRY_AW-1:0] item_addr;
  logic [31:0]         item_latency;
  logic [31:0]         item_wait_time;
  logic                item_succeeded;
  logic [31:0]         table_cnt [TABLE_COUNT];

  logic                ram_we;
  logic                ram_re;
  logic [ENTRY_AW-1:0] ram_waddr;
  entry_t              ram_wdata;
  entry_t              rd_entry;
  entry_t              upd_entry;
  logic                out_load;
  logic                seed;
  logic [31:0]         cur_min;
  logic [31:0]         cur_max;
  logic [31:0]         treq_new;
  logic [31:0]         res_total;
  logic [31:0]         res_min;
  logic [31:0]         res_max;
  logic [31:0]         res_treq;

  assign in_program_req = s_tdata[31:0];
  assign in_version = s_tdata[39:32];
  assign in_procedure = s_tdata[47:40];
  assign in_latency = s_tdata[79:48];
  assign in_wait_time = s_tdata[111:80];
  assign in_succeeded = s_tdata[112];
  assign accept = s_tvalid && s_tready;

  rlst_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlst_decode #(
    .PROC_SLOTS (PROC_SLOTS)
  ) u_decode (
    .cfg         (cfg),
    .program_req (in_program_req),
    .version     (in_version),
    .procedure   (in_procedure),
    .sel         (in_sel)
  );

  assign rd_addr = ENTRY_AW'(in_sel.slot) * ENTRY_AW'(PROC_SLOTS) + ENTRY_AW'(in_procedure);

  rlst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  always_comb begin
    seed = rd_entry.total == 32'd0;
    cur_min = seed ? item_latency : rd_entry.min_lat;
    cur_max = seed ? item_latency : rd_entry.max_lat;
    upd_entry.total = rd_entry.total + 32'd1;
    upd_entry.success = rd_entry.success + {31'd0, item_succeeded};
    upd_entry.dropped = rd_entry.dropped + {31'd0, !item_succeeded};
    upd_entry.min_lat = cur_min;
    upd_entry.max_lat = cur_max;
    if (item_latency > cur_max) begin
      upd_entry.max_lat = item_latency;
    end else if (item_latency < cur_min) begin
      upd_entry.min_lat = item_latency;
    end
    upd_entry.lat_sum = rd_entry.lat_sum + {32'd0, item_latency};
    upd_entry.wait_sum = rd_entry.wait_sum + {32'd0, item_wait_time};
    treq_new = table_cnt[item_sel.slot] + 32'd1;
    if (item_sel.status == STATUS_OK) begin
      res_total = upd_entry.total;
      res_min = upd_entry.min_lat;
      res_max = upd_entry.max_lat;
      res_treq = treq_new;
    end else begin
      res_total = 32'd0;
      res_min = 32'd0;
      res_max = 32'd0;
      res_treq = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_waddr = item_addr;
    ram_wdata = upd_entry;
    out_load = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == LAST_ENTRY) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        ram_re = accept;
        if (accept) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          ram_we = item_sel.status == STATUS_OK;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + ENTRY_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_sel <= in_sel;
      item_addr <= rd_addr;
      item_latency <= in_latency;
      item_wait_time <= in_wait_time;
      item_succeeded <= in_succeeded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_COUNT; i++) begin
        table_cnt[i] <= 32'd0;
      end
    end else if (out_load && item_sel.status == STATUS_OK) begin
      table_cnt[item_sel.slot] <= treq_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'd0, res_treq, res_max, res_min, res_total, item_sel.slot, item_sel.status};
    end
  end

endmodule

@@ design/rlst_checker.sv @@
// Port-level checks for the RPC request latency statistics block and their binding.
module rlst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rlst_pkg::M_TDATA_W-1:0] m_tdata
);
  import rlst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result transfer changed.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input taken again while an update is in flight.");

  a_lookup_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == STATUS_BAD_PROG || m_tdata[1:0] == STATUS_BAD_VERS)
    |-> m_tdata[M_TDATA_W-1:2] == '0)
    else $error("Lookup error result carries nonzero fields.");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == STATUS_OK |-> m_tdata[68:37] <= m_tdata[100:69])
    else $error("Recorded result has minimum latency above maximum.");

endmodule

bind rpc_request_latency_stats_top rlst_checker u_rlst_checker (.*);

@@ verif/tb_rpc_request_latency_stats_top.sv @@
// Self-checking testbench for the RPC request latency statistics block.
`timescale 1ns / 100ps
module tb_rpc_request_latency_stats_top;
  import rlst_pkg::*;

  localparam int PROC_SLOTS = 32;
  localparam int ENTRIES = TABLE_COUNT * PROC_SLOTS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS = 180;
  localparam int PHASES = 6;

  localparam logic [7:0] VERS1 = 8'd1;
  localparam logic [7:0] VERS2 = 8'd2;
  localparam logic [7:0] VERS3 = 8'd3;
  localparam logic [7:0] VERS4 = 8'd4;

  // Fields are listed from the highest bit down to match the stream layout.
  typedef struct packed {
    logic        ok;
    logic [31:0] wait_ms;
    logic [31:0] lat;
    logic [7:0]  proc;
    logic [7:0]  vers;
    logic [31:0] prog;
  } record_t;

  typedef struct packed {
    logic [31:0]       table_reqs;
    logic [31:0]       max_lat;
    logic [31:0]       min_lat;
    logic [31:0]       total;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        status;
  } stats_t;

  typedef enum int {KIND_FILE, KIND_MOUNT, KIND_LOCK, KIND_QUOTA} prog_kind_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE, RX_PULSE} rx_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_AW-1:0]      paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  cfg_t        cfg_shadow;
  logic [31:0] ent_total[ENTRIES];
  logic [31:0] ent_success[ENTRIES];
  logic [31:0] ent_dropped[ENTRIES];
  logic [31:0] ent_min[ENTRIES];
  logic [31:0] ent_max[ENTRIES];
  logic [63:0] ent_lat_sum[ENTRIES];
  logic [63:0] ent_wait_sum[ENTRIES];
  logic [31:0] table_reqs[TABLE_COUNT];

  stats_t expected_stats[$];
  int     error_count = 0;
  int     burst_left = 0;

  rpc_request_latency_stats_top #(.PROC_SLOTS(PROC_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_stats();
    cfg_shadow = '{FILE_PROG_RST, MOUNT_PROG_RST, LOCK_PROG_RST, QUOTA_PROG_RST, 1'b1, 1'b1};
    foreach (ent_total[i]) begin
      ent_total[i] = '0;
      ent_success[i] = '0;
      ent_dropped[i] = '0;
      ent_min[i] = '0;
      ent_max[i] = '0;
      ent_lat_sum[i] = '0;
      ent_wait_sum[i] = '0;
    end
    foreach (table_reqs[i]) table_reqs[i] = '0;
  endfunction

  function automatic stats_t update_stats(input record_t r);
    stats_t            res;
    logic [SLOT_W-1:0] slot;
    int                e;
    res = '0;
    slot = SLOT_FILE2;
    res.status = STATUS_OK;
    if (r.prog == cfg_shadow.file_prog) begin
      case (r.vers)
        VERS2: slot = SLOT_FILE2;
        VERS3: slot = SLOT_FILE3;
        VERS4: slot = SLOT_FILE4;
        default: res.status = STATUS_BAD_VERS;
      endcase
    end else if (r.prog == cfg_shadow.mount_prog) begin
      case (r.vers)
        VERS1: slot = SLOT_MNT1;
        VERS3: slot = SLOT_MNT3;
        default: res.status = STATUS_BAD_VERS;
      endcase
    end else if (cfg_shadow.lock_en && r.prog == cfg_shadow.lock_prog) begin
      if (r.vers == VERS4) slot = SLOT_LOCK4;
      else res.status = STATUS_BAD_VERS;
    end else if (cfg_shadow.quota_en && r.prog == cfg_shadow.quota_prog) begin
      case (r.vers)
        VERS1: slot = SLOT_QUOTA1;
        VERS2: slot = SLOT_QUOTA2;
        default: res.status = STATUS_BAD_VERS;
      endcase
    end else begin
      res.status = STATUS_BAD_PROG;
    end
    if (res.status != STATUS_OK) return res;
    res.slot = slot;
    if (int'(r.proc) >= PROC_SLOTS) begin
      res.status = STATUS_BAD_PROC;
      return res;
    end
    e = int'(slot) * PROC_SLOTS + int'(r.proc);
    table_reqs[slot] = table_reqs[slot] + 32'd1;
    if (ent_total[e] == '0) begin
      ent_min[e] = r.lat;
      ent_max[e] = r.lat;
    end
    ent_lat_sum[e] = ent_lat_sum[e] + {32'd0, r.lat};
    if (r.lat > ent_max[e]) ent_max[e] = r.lat;
    else if (r.lat < ent_min[e]) ent_min[e] = r.lat;
    ent_wait_sum[e] = ent_wait_sum[e] + {32'd0, r.wait_ms};
    ent_total[e] = ent_total[e] + 32'd1;
    if (r.ok) ent_success[e] = ent_success[e] + 32'd1;
    else ent_dropped[e] = ent_dropped[e] + 32'd1;
    res.total = ent_total[e];
    res.min_lat = ent_min[e];
    res.max_lat = ent_max[e];
    res.table_reqs = table_reqs[slot];
    return res;
  endfunction

  function automatic record_t make_rec(input logic [31:0] prog, input logic [7:0] vers,
                                       input logic [7:0] proc, input logic [31:0] lat,
                                       input logic [31:0] wait_ms, input logic ok);
    record_t r;
    r.prog = prog;
    r.vers = vers;
    r.proc = proc;
    r.lat = lat;
    r.wait_ms = wait_ms;
    r.ok = ok;
    return r;
  endfunction

  function automatic record_t random_record();
    record_t    r;
    prog_kind_t kind;
    int         pick;
    kind = prog_kind_t'($urandom_range(0, 3));
    case (kind)
      KIND_FILE: begin
        r.prog = cfg_shadow.file_prog;
        r.vers = VERS2 + 8'($urandom_range(0, 2));
      end
      KIND_MOUNT: begin
        r.prog = cfg_shadow.mount_prog;
        r.vers = ($urandom_range(0, 1) == 1) ? VERS3 : VERS1;
      end
      KIND_LOCK: begin
        r.prog = cfg_shadow.lock_prog;
        r.vers = VERS4;
      end
      default: begin
        r.prog = cfg_shadow.quota_prog;
        r.vers = VERS1 + 8'($urandom_range(0, 1));
      end
    endcase
    if ($urandom_range(0, 99) < 12) r.prog = $urandom;
    if ($urandom_range(0, 99) < 12) r.vers = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 50) r.proc = 8'($urandom_range(0, 7));
    else if (pick < 90) r.proc = 8'($urandom_range(0, PROC_SLOTS - 1));
    else r.proc = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 10) r.lat = '0;
    else if (pick < 20) r.lat = '1;
    else if (pick < 50) r.lat = $urandom_range(1, 1000);
    else r.lat = $urandom;
    r.wait_ms = ($urandom_range(0, 9) == 0) ? '1 : $urandom;
    r.ok = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic cfg_t random_config();
    cfg_t        c;
    logic [31:0] progs[4];
    logic [31:0] defaults[4];
    defaults = '{FILE_PROG_RST, MOUNT_PROG_RST, LOCK_PROG_RST, QUOTA_PROG_RST};
    foreach (progs[i]) begin
      case ($urandom_range(0, 4))
        0: progs[i] = defaults[i];
        1: progs[i] = '0;
        2: progs[i] = '1;
        3: progs[i] = (i > 0) ? progs[$urandom_range(0, i - 1)] : $urandom;
        default: progs[i] = $urandom;
      endcase
    end
    c = '{progs[0], progs[1], progs[2], progs[3], 1'($urandom_range(0, 1)),
          1'($urandom_range(0, 1))};
    return c;
  endfunction

  task automatic send_record(input record_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_TDATA_W - $bits(record_t)){1'b0}}, r};
    do @(posedge clk); while (!s_tready);
    expected_stats.push_back(update_stats(r));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FILE_PROG: cfg_shadow.file_prog = value;
      REG_MOUNT_PROG: cfg_shadow.mount_prog = value;
      REG_LOCK_PROG: cfg_shadow.lock_prog = value;
      REG_QUOTA_PROG: cfg_shadow.quota_prog = value;
      REG_LOCK_EN: cfg_shadow.lock_en = value[0];
      REG_QUOTA_EN: cfg_shadow.quota_en = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    logic [31:0] fill;
    drain();
    write_reg(REG_FILE_PROG, c.file_prog);
    write_reg(REG_MOUNT_PROG, c.mount_prog);
    write_reg(REG_LOCK_PROG, c.lock_prog);
    write_reg(REG_QUOTA_PROG, c.quota_prog);
    fill = $urandom;
    write_reg(REG_LOCK_EN, {fill[31:1], c.lock_en});
    fill = $urandom;
    write_reg(REG_QUOTA_EN, {fill[31:1], c.quota_en});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed();
    send_record(make_rec(FILE_PROG_RST, VERS2, 8'd0, 32'd0, 32'd0, 1'b0));
    send_record(make_rec(FILE_PROG_RST, VERS2, 8'd0, '1, '1, 1'b1));
    send_record(make_rec(FILE_PROG_RST, VERS2, 8'd0, 32'd5, 32'd7, 1'b1));
    send_record(make_rec(FILE_PROG_RST, VERS3, 8'd31, 32'd1000, 32'd3, 1'b1));
    send_record(make_rec(FILE_PROG_RST, VERS3, 8'd31, 32'd500, 32'd3, 1'b0));
    send_record(make_rec(FILE_PROG_RST, VERS3, 8'd31, 32'd2000, 32'd3, 1'b1));
    send_record(make_rec(FILE_PROG_RST, VERS3, 8'd31, 32'd1000, 32'd3, 1'b0));
    send_record(make_rec(FILE_PROG_RST, VERS4, 8'd7, 32'h8000_0000, '1, 1'b1));
    send_record(make_rec(MOUNT_PROG_RST, VERS1, 8'd0, 32'd12, 32'd0, 1'b0));
    send_record(make_rec(MOUNT_PROG_RST, VERS3, 8'd31, '1, 32'd9, 1'b1));
    send_record(make_rec(LOCK_PROG_RST, VERS4, 8'd1, 32'd44, 32'd1, 1'b1));
    send_record(make_rec(QUOTA_PROG_RST, VERS1, 8'd2, 32'd0, '1, 1'b0));
    send_record(make_rec(QUOTA_PROG_RST, VERS2, 8'd30, 32'h7FFF_FFFF, 32'd2, 1'b1));
    send_record(make_rec(FILE_PROG_RST, VERS1, 8'd0, 32'd1, 32'd1, 1'b1));
    send_record(make_rec(MOUNT_PROG_RST, VERS2, 8'd0, 32'd1, 32'd1, 1'b1));
    send_record(make_rec(LOCK_PROG_RST, VERS3, 8'd0, 32'd1, 32'd1, 1'b1));
    send_record(make_rec(QUOTA_PROG_RST, 8'd255, 8'd0, 32'd1, 32'd1, 1'b1));
    send_record(make_rec(32'd0, VERS2, 8'd0, 32'd1, 32'd1, 1'b1));
    send_record(make_rec('1, VERS2, 8'd0, 32'd1, 32'd1, 1'b1));
    send_record(make_rec(FILE_PROG_RST, VERS2, 8'd32, 32'd1, 32'd1, 1'b1));
    send_record(make_rec(QUOTA_PROG_RST, VERS2, 8'd255, 32'd1, 32'd1, 1'b0));
    send_record(make_rec(LOCK_PROG_RST, VERS4, 8'd128, 32'd1, 32'd1, 1'b1));
    drain();
  endtask

  // Overlapping program numbers check the match order and the enables.
  task automatic test_program_priority();
    apply_config('{'1, '1, '1, '1, 1'b1, 1'b1});
    send_record(make_rec('1, VERS2, 8'd4, 32'd10, 32'd0, 1'b1));
    send_record(make_rec('1, VERS1, 8'd4, 32'd10, 32'd0, 1'b1));
    send_record(make_rec('1, VERS4, 8'd4, '1, 32'd0, 1'b0));
    apply_config('{32'd0, 32'd0, 32'd1, 32'd1, 1'b1, 1'b1});
    send_record(make_rec(32'd0, VERS1, 8'd3, 32'd6, 32'd0, 1'b1));
    send_record(make_rec(32'd0, VERS3, 8'd3, 32'd6, 32'd0, 1'b1));
    send_record(make_rec(32'd1, VERS4, 8'd3, 32'd6, 32'd0, 1'b1));
    send_record(make_rec(32'd1, VERS1, 8'd3, 32'd6, 32'd0, 1'b1));
    apply_config('{32'd0, 32'd0, 32'd1, 32'd1, 1'b0, 1'b1});
    send_record(make_rec(32'd1, VERS1, 8'd3, 32'd6, 32'd0, 1'b1));
    send_record(make_rec(32'd1, VERS4, 8'd3, 32'd6, 32'd0, 1'b1));
    apply_config('{32'd0, 32'd0, 32'd1, 32'd1, 1'b0, 1'b0});
    send_record(make_rec(32'd1, VERS1, 8'd3, 32'd6, 32'd0, 1'b1));
    send_record(make_rec(32'd1, VERS4, 8'd3, 32'd6, 32'd0, 1'b1));
    drain();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        apply_config('{FILE_PROG_RST, MOUNT_PROG_RST, LOCK_PROG_RST, QUOTA_PROG_RST,
                       1'b1, 1'b1});
      end else begin
        apply_config(random_config());
      end
      repeat (PHASE_ITEMS) send_record(random_record());
    end
    drain();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  initial begin : result_checker
    stats_t   want;
    stats_t   got;
    rx_mode_t rx_mode;
    int       rx_left;
    rx_mode = RX_OPEN;
    rx_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = stats_t'(m_tdata[$bits(stats_t)-1:0]);
        if (expected_stats.size() == 0) begin
          error_count++;
          $display("%0t: result mismatch: expected none, actual %0h", $time, m_tdata);
        end else begin
          want = expected_stats.pop_front();
          check_field("status", want.status, got.status);
          check_field("table_slot", want.slot, got.slot);
          check_field("entry_total", want.total, got.total);
          check_field("entry_min_latency", want.min_lat, got.min_lat);
          check_field("entry_max_latency", want.max_lat, got.max_lat);
          check_field("table_requests", want.table_reqs, got.table_reqs);
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN: m_tready <= 1'b1;
        RX_COIN: m_tready <= 1'($urandom_range(0, 1));
        RX_CHOKE: m_tready <= ($urandom_range(0, 7) == 0);
        default: m_tready <= (rx_left % 5 != 0);
      endcase
    end
  end

  initial begin : watchdog
    int cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    reset_stats();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_program_priority();
    test_random_traffic();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
